// ----- hdl/tis_pkg.sv -----
// Package for the turn indicator with steering self-cancel.
// Holds the side codes, the register map and the configuration record.
// No dependencies.
package tis_pkg;

   // Width of the configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Fixed widths of the configuration registers
   localparam int CFG_HP_W  = 32;
   localparam int CFG_THR_W = 12;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_THR     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_LOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_HIGH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_THR    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_REV    = 3'd5;

   // Register reset values
   localparam logic [CFG_HP_W-1:0]  RST_HALF_PERIOD = 32'd50000000;
   localparam logic [CFG_THR_W-1:0] RST_LEFT_THR    = 12'd1400;
   localparam logic [CFG_THR_W-1:0] RST_CENTRE_LOW  = 12'd1800;
   localparam logic [CFG_THR_W-1:0] RST_CENTRE_HIGH = 12'd2300;
   localparam logic [CFG_THR_W-1:0] RST_RIGHT_THR   = 12'd2700;

   // Selected side, also the direction code of a result item
   typedef enum logic [1:0] {
      SIDE_NONE  = 2'd0,
      SIDE_LEFT  = 2'd1,
      SIDE_RIGHT = 2'd2
   } side_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [CFG_HP_W-1:0]  blink_half_period;
      logic [CFG_THR_W-1:0] left_threshold;
      logic [CFG_THR_W-1:0] centre_low;
      logic [CFG_THR_W-1:0] centre_high;
      logic [CFG_THR_W-1:0] right_threshold;
      logic                 steering_reversed;
   } cfg_type;

endpackage

// ----- hdl/tis_chan_if.sv -----
// Channel interfaces of the turn indicator: poll samples, results and
// register writes. Depends on tis_pkg for the register port widths.
interface tis_req_if #(parameter int ADC_BITS = 12, parameter int TIMER_BITS = 32);
   logic                  valid;
   logic                  ready;
   logic                  left_switch;
   logic                  right_switch;
   logic [ADC_BITS-1:0]   steering_raw;
   logic [TIMER_BITS-1:0] timestamp;

   modport source (output valid, left_switch, right_switch, steering_raw, timestamp,
                   input ready);
   modport sink   (input valid, left_switch, right_switch, steering_raw, timestamp,
                   output ready);
endinterface

interface tis_rsp_if;
   logic       valid;
   logic       ready;
   logic       left_lamp;
   logic       right_lamp;
   logic       buzzer;
   logic [1:0] direction;

   modport source (output valid, left_lamp, right_lamp, buzzer, direction, input ready);
   modport sink   (input valid, left_lamp, right_lamp, buzzer, direction, output ready);
endinterface

interface tis_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tis_pkg::CSR_IDX_W-1:0]   index;
   logic [tis_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/turn_indicator_self_cancel.sv -----
// Top level of the turn indicator with steering self-cancel.
// Depends on tis_pkg, the channel interfaces in tis_chan_if and tis_csr.
//
//   channel    role     item
//   req_chan   sink     switch levels, steering reading, timestamp
//   rsp_chan   source   left lamp, right lamp, buzzer, direction
//   csr_chan   sink     register index and write data
//
// One sample a cycle if not stalled; its result is registered next cycle.
// The state update and the result come from one pass of compare and subtract
// logic between the sample on the port and the state and output registers.
// A stalled result holds; a new sample is taken in the cycle it is drained.
// Reset is synchronous; registers are writable from the first cycle after it.
module turn_indicator_self_cancel #(
   parameter int TIMER_BITS = 32,
   parameter int ADC_BITS   = 12
) (
   input logic clock,
   input logic reset,
   tis_req_if.sink   req_chan,
   tis_rsp_if.source rsp_chan,
   tis_csr_if.sink   csr_chan
);
   import tis_pkg::*;

   localparam int CMP_W = (ADC_BITS > CFG_THR_W) ? ADC_BITS : CFG_THR_W;
   localparam int HP_W  = (TIMER_BITS > CFG_HP_W) ? TIMER_BITS : CFG_HP_W;

   cfg_type cfg;

   // State
   logic                  primed_ff;
   logic                  prev_left_ff,  prev_left_in;
   logic                  prev_right_ff, prev_right_in;
   side_type              side_ff,       side_in;
   logic                  seen_ff,       seen_in;
   logic                  phase_ff,      phase_in;
   logic [TIMER_BITS-1:0] last_ff,       last_in;

   // Result register
   logic     rsp_valid_ff;
   logic     left_lamp_ff,  left_lamp_in;
   logic     right_lamp_ff, right_lamp_in;
   logic     buzzer_ff,     buzzer_in;
   side_type direction_ff;

   // Datapath
   logic [ADC_BITS-1:0]   steer;
   logic [CMP_W-1:0]      steer_cmp;
   logic                  turned_left, turned_right, in_centre;
   logic                  left_edge, right_edge, restart;
   side_type              side_sel;
   logic                  seen_sel, phase_sel;
   logic [TIMER_BITS-1:0] last_sel, elapsed;
   logic                  due;
   logic                  accept;

   tis_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // Take a sample whenever the result register is free or being drained
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.left_lamp  = left_lamp_ff;
   assign rsp_chan.right_lamp = right_lamp_ff;
   assign rsp_chan.buzzer     = buzzer_ff;
   assign rsp_chan.direction  = direction_ff;

   // Steering position and its bands
   always_comb begin
      steer        = cfg.steering_reversed ? ~req_chan.steering_raw : req_chan.steering_raw;
      steer_cmp    = CMP_W'(steer);
      turned_left  = steer_cmp <= CMP_W'(cfg.left_threshold);
      turned_right = steer_cmp >= CMP_W'(cfg.right_threshold);
      in_centre    = (steer_cmp >= CMP_W'(cfg.centre_low)) &&
                     (steer_cmp <= CMP_W'(cfg.centre_high));
   end

   // Switch edges select a side and restart the blink; left wins
   always_comb begin
      left_edge  = prev_left_ff && !req_chan.left_switch;
      right_edge = !left_edge && prev_right_ff && !req_chan.right_switch;
      restart    = left_edge || right_edge;
      side_sel   = left_edge ? SIDE_LEFT : (right_edge ? SIDE_RIGHT : side_ff);
      seen_sel   = restart ? 1'b0 : seen_ff;
      phase_sel  = restart ? 1'b1 : phase_ff;
      last_sel   = restart ? req_chan.timestamp : last_ff;
      elapsed    = req_chan.timestamp - last_sel;
      due        = HP_W'(elapsed) >= HP_W'(cfg.blink_half_period);
   end

   // Blink, self-cancel and buzzer
   always_comb begin
      prev_left_in  = req_chan.left_switch;
      prev_right_in = req_chan.right_switch;
      side_in       = side_ff;
      seen_in       = seen_ff;
      phase_in      = phase_ff;
      last_in       = last_ff;
      buzzer_in     = 1'b0;
      left_lamp_in  = 1'b0;
      right_lamp_in = 1'b0;
      if (!primed_ff) begin
         // First sample only records history
         last_in = req_chan.timestamp;
      end else begin
         side_in  = side_sel;
         seen_in  = seen_sel;
         phase_in = phase_sel;
         last_in  = last_sel;
         if (side_sel == SIDE_NONE) begin
            phase_in = 1'b0;
         end else if (due) begin
            last_in  = req_chan.timestamp;
            phase_in = !phase_sel;
         end
         if (side_sel == SIDE_LEFT) begin
            seen_in   = seen_sel || turned_left;
            buzzer_in = turned_right;
         end else if (side_sel == SIDE_RIGHT) begin
            seen_in   = seen_sel || turned_right;
            buzzer_in = turned_left;
         end
         if (side_sel != SIDE_NONE && seen_in && in_centre) begin
            side_in   = SIDE_NONE;
            phase_in  = 1'b0;
            buzzer_in = 1'b0;
         end
         left_lamp_in  = (side_in == SIDE_LEFT)  && phase_in;
         right_lamp_in = (side_in == SIDE_RIGHT) && phase_in;
      end
   end

   // Advance state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff     <= 1'b0;
         prev_left_ff  <= 1'b1;
         prev_right_ff <= 1'b1;
         side_ff       <= SIDE_NONE;
         seen_ff       <= 1'b0;
         phase_ff      <= 1'b0;
         last_ff       <= '0;
      end else if (accept) begin
         primed_ff     <= 1'b1;
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         side_ff       <= side_in;
         seen_ff       <= seen_in;
         phase_ff      <= phase_in;
         last_ff       <= last_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         left_lamp_ff  <= left_lamp_in;
         right_lamp_ff <= right_lamp_in;
         buzzer_ff     <= buzzer_in;
         direction_ff  <= side_in;
      end
   end

`ifndef SYNTH
   a_one_lamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(left_lamp_ff && right_lamp_ff))
      else $error("both lamps lit");

   a_lamp_side: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (left_lamp_ff || right_lamp_ff) |->
         ((left_lamp_ff && direction_ff == SIDE_LEFT) ||
          (right_lamp_ff && direction_ff == SIDE_RIGHT)))
      else $error("lamp lit on the unselected side");

   a_buzz_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && buzzer_ff |-> direction_ff != SIDE_NONE)
      else $error("buzzer with no side selected");

   a_prime: assert property (@(posedge clock) disable iff (reset)
      accept && !primed_ff |=> primed_ff && rsp_valid_ff && !left_lamp_ff &&
                               !right_lamp_ff && !buzzer_ff)
      else $error("priming sample mishandled");

   a_idle_dark: assert property (@(posedge clock) disable iff (reset)
      side_ff == SIDE_NONE |-> !phase_ff)
      else $error("blink phase set with no side selected");
`endif

endmodule

// ----- hdl/tis_csr.sv -----
// Configuration register file of the turn indicator.
// Depends on tis_pkg and the tis_csr_if channel.
module tis_csr (
   input  logic             clock,
   input  logic             reset,
   tis_csr_if.sink          csr_chan,
   output tis_pkg::cfg_type cfg
);
   import tis_pkg::*;

   cfg_type cfg_ff;

   // Writes are always taken
   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   // Load the addressed register; drop writes beyond the map
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_half_period <= RST_HALF_PERIOD;
         cfg_ff.left_threshold    <= RST_LEFT_THR;
         cfg_ff.centre_low        <= RST_CENTRE_LOW;
         cfg_ff.centre_high       <= RST_CENTRE_HIGH;
         cfg_ff.right_threshold   <= RST_RIGHT_THR;
         cfg_ff.steering_reversed <= 1'b0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_HALF_PERIOD: cfg_ff.blink_half_period <= csr_chan.data[CFG_HP_W-1:0];
            CSR_LEFT_THR:    cfg_ff.left_threshold    <= csr_chan.data[CFG_THR_W-1:0];
            CSR_CENTRE_LOW:  cfg_ff.centre_low        <= csr_chan.data[CFG_THR_W-1:0];
            CSR_CENTRE_HIGH: cfg_ff.centre_high       <= csr_chan.data[CFG_THR_W-1:0];
            CSR_RIGHT_THR:   cfg_ff.right_threshold   <= csr_chan.data[CFG_THR_W-1:0];
            CSR_STEER_REV:   cfg_ff.steering_reversed <= csr_chan.data[0];
            default: ;
         endcase
      end
   end

endmodule
